### hdl/i2c_register_transfer_sequencer_macros.svh
// Assertion macros shared by the checker of the I2C register transfer sequencer.
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while reset is held.
`define I2C_RTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2c_rts: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and disabled while reset is held.
`define I2C_RTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2c_rts: next-cycle check failed");

`endif

### hdl/i2c_rts_pkg.sv
// Types and constants of the I2C register transfer sequencer.
package i2c_rts_pkg;

    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_REP_START = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;
    localparam logic [7:0] READ_BIT     = 8'h01;

    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_WRITE  = 3'd2;
    localparam logic [2:0] ACT_RSTART = 3'd3;
    localparam logic [2:0] ACT_RACK   = 3'd4;
    localparam logic [2:0] ACT_RNACK  = 3'd5;
    localparam logic [2:0] ACT_STOP   = 3'd6;

    localparam logic [2:0] RES_BUSY   = 3'd0;
    localparam logic [2:0] RES_OK     = 3'd1;
    localparam logic [2:0] RES_ESTART = 3'd2;
    localparam logic [2:0] RES_EADDR  = 3'd3;
    localparam logic [2:0] RES_EWRITE = 3'd4;
    localparam logic [2:0] RES_ERST   = 3'd5;
    localparam logic [2:0] RES_EREAD  = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_START  = 3'd1,
        PH_SLAW   = 3'd2,
        PH_REG    = 3'd3,
        PH_WDATA  = 3'd4,
        PH_RSTART = 3'd5,
        PH_SLAR   = 3'd6,
        PH_RDATA  = 3'd7
    } t_phase;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] device_address;
        logic [7:0] register_index;
        logic [7:0] byte_count;
        logic [7:0] bus_status;
        logic [7:0] write_byte;
        logic [7:0] read_byte;
    } t_in_word;

    typedef struct packed {
        logic       accepted;
        logic [2:0] bus_action;
        logic [7:0] bus_byte;
        logic [7:0] byte_index;
        logic       store_valid;
        logic [7:0] store_byte;
        logic [2:0] op_result;
        logic [7:0] error_status;
        logic       busy_res;
    } t_out_word;

    // Transfer context kept between steps, apart from the phase.
    typedef struct packed {
        logic       is_write;
        logic [7:0] target_address;
        logic [7:0] target_register;
        logic [7:0] total_bytes;
        logic [7:0] done_bytes;
        logic [7:0] last_error_code;
        logic [2:0] result_code;
    } t_ctx;

endpackage

### hdl/i2c_rts_step.sv
// One sequencer step: next phase, next context and the result word.
module i2c_rts_step (
    input  i2c_rts_pkg::t_phase    i_phase,
    input  i2c_rts_pkg::t_ctx      i_ctx,
    input  i2c_rts_pkg::t_in_word  i_word,
    output i2c_rts_pkg::t_phase    o_phase,
    output i2c_rts_pkg::t_ctx      o_ctx,
    output i2c_rts_pkg::t_out_word o_word
);
    import i2c_rts_pkg::*;

    logic       start_ok;
    logic       is_event;
    logic [7:0] done_p1;
    logic [7:0] done_p2;
    logic       last_rx;
    logic       write_done;
    logic [7:0] expected;
    logic       status_ok;
    t_ctx       ctx_n;
    logic [2:0] action;
    logic [7:0] bus_byte;
    logic [7:0] index;
    logic       store_valid;
    logic [7:0] store_byte;

    assign start_ok   = (i_word.command == CMD_WRITE || i_word.command == CMD_READ)
                        && (i_phase == PH_IDLE);
    assign is_event   = (i_word.command == CMD_EVENT);
    assign done_p1    = i_ctx.done_bytes + 8'd1;
    assign done_p2    = i_ctx.done_bytes + 8'd2;
    assign last_rx    = (done_p1 == i_ctx.total_bytes);
    assign write_done = (i_ctx.done_bytes == i_ctx.total_bytes);

    always_comb begin
        case (i_phase)
            PH_START:  expected = ST_START;
            PH_SLAW:   expected = ST_SLAW_ACK;
            PH_REG:    expected = ST_DATA_ACK;
            PH_WDATA:  expected = ST_DATA_ACK;
            PH_RSTART: expected = ST_REP_START;
            PH_SLAR:   expected = ST_SLAR_ACK;
            PH_RDATA:  expected = last_rx ? ST_RX_NACK : ST_RX_ACK;
            default:   expected = ST_START;
        endcase
    end

    assign status_ok = (i_word.bus_status == expected);

    // Next phase.
    always_comb begin
        o_phase = i_phase;
        if (start_ok) begin
            o_phase = PH_START;
        end else if (is_event && i_phase != PH_IDLE) begin
            if (!status_ok) begin
                o_phase = PH_IDLE;
            end else begin
                case (i_phase)
                    PH_START:  o_phase = PH_SLAW;
                    PH_SLAW:   o_phase = PH_REG;
                    PH_REG:    o_phase = i_ctx.is_write ? PH_WDATA : PH_RSTART;
                    PH_WDATA:  o_phase = write_done ? PH_IDLE : PH_WDATA;
                    PH_RSTART: o_phase = PH_SLAR;
                    PH_SLAR:   o_phase = PH_RDATA;
                    PH_RDATA:  o_phase = last_rx ? PH_IDLE : PH_RDATA;
                    default:   o_phase = i_phase;
                endcase
            end
        end
    end

    // Bus action, data path and context update.
    always_comb begin
        ctx_n       = i_ctx;
        action      = ACT_NONE;
        bus_byte    = 8'd0;
        index       = 8'd0;
        store_valid = 1'b0;
        store_byte  = 8'd0;
        if (start_ok) begin
            ctx_n.is_write        = (i_word.command == CMD_WRITE);
            ctx_n.target_address  = i_word.device_address;
            ctx_n.target_register = i_word.register_index;
            ctx_n.total_bytes     = i_word.byte_count;
            ctx_n.done_bytes      = 8'd0;
            ctx_n.result_code     = RES_BUSY;
            action                = ACT_START;
        end else if (is_event && i_phase != PH_IDLE) begin
            if (!status_ok) begin
                ctx_n.last_error_code = i_word.bus_status;
                action                = ACT_STOP;
                case (i_phase)
                    PH_START: begin
                        ctx_n.result_code = RES_ESTART;
                        action            = ACT_NONE;
                    end
                    PH_SLAW:   ctx_n.result_code = RES_EADDR;
                    PH_REG:    ctx_n.result_code = RES_EWRITE;
                    PH_WDATA:  ctx_n.result_code = RES_EWRITE;
                    PH_RSTART: ctx_n.result_code = RES_ERST;
                    default:   ctx_n.result_code = RES_EREAD;
                endcase
            end else begin
                case (i_phase)
                    PH_START: begin
                        action   = ACT_WRITE;
                        bus_byte = i_ctx.target_address;
                    end
                    PH_SLAW: begin
                        action   = ACT_WRITE;
                        bus_byte = i_ctx.target_register;
                    end
                    PH_REG: begin
                        if (i_ctx.is_write) begin
                            action           = ACT_WRITE;
                            bus_byte         = i_word.write_byte;
                            index            = i_ctx.done_bytes;
                            ctx_n.done_bytes = done_p1;
                        end else begin
                            action = ACT_RSTART;
                        end
                    end
                    PH_WDATA: begin
                        if (write_done) begin
                            ctx_n.result_code = RES_OK;
                            action            = ACT_STOP;
                        end else begin
                            action           = ACT_WRITE;
                            bus_byte         = i_word.write_byte;
                            index            = i_ctx.done_bytes;
                            ctx_n.done_bytes = done_p1;
                        end
                    end
                    PH_RSTART: begin
                        action   = ACT_WRITE;
                        bus_byte = i_ctx.target_address | READ_BIT;
                    end
                    PH_SLAR: begin
                        action = (i_ctx.total_bytes == 8'd1) ? ACT_RNACK : ACT_RACK;
                    end
                    PH_RDATA: begin
                        store_valid      = 1'b1;
                        store_byte       = i_word.read_byte;
                        index            = i_ctx.done_bytes;
                        ctx_n.done_bytes = done_p1;
                        if (last_rx) begin
                            ctx_n.result_code = RES_OK;
                            action            = ACT_STOP;
                        end else begin
                            action = (done_p2 == i_ctx.total_bytes) ? ACT_RNACK : ACT_RACK;
                        end
                    end
                    default: action = ACT_NONE;
                endcase
            end
        end
    end

    assign o_ctx = ctx_n;

    always_comb begin
        o_word.accepted     = start_ok;
        o_word.bus_action   = action;
        o_word.bus_byte     = bus_byte;
        o_word.byte_index   = index;
        o_word.store_valid  = store_valid;
        o_word.store_byte   = store_byte;
        o_word.op_result    = ctx_n.result_code;
        o_word.error_status = ctx_n.last_error_code;
        o_word.busy_res     = (o_phase != PH_IDLE);
    end

endmodule

### hdl/i2c_register_transfer_sequencer.sv
// Top level of the I2C register transfer sequencer: input register, step logic, result register.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+---------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_in_word  (t_in_word)
//   out     | from block| o_out_valid / i_out_stall  | o_out_word (t_out_word)
//
// Every accepted word gives exactly one result word, which passes the input register
// and then the result register. One word is taken per cycle while the output side
// does not stall: the input register feeds the step logic, and the step updates the
// sequencer state in the same edge at which it loads the result register, so the
// next word sees it. Reset (i_rst_n low at a clock edge) empties both registers and
// returns the sequencer to idle with a cleared context. A stall on the output holds
// the result register and, once the input register is full, raises o_in_stall.
module i2c_register_transfer_sequencer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  i2c_rts_pkg::t_in_word  i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output i2c_rts_pkg::t_out_word o_out_word
);
    import i2c_rts_pkg::*;

    // Input stage.
    logic      r_in_valid;
    t_in_word  r_in_word;

    // Sequencer state.
    t_phase    r_phase;
    t_phase    n_phase;
    t_ctx      r_ctx;
    t_ctx      n_ctx;

    // Result stage.
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    logic      out_free;
    logic      advance;
    logic      in_take;

    // The result register can load when it is empty or being emptied this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    // A held word moves through the step logic whenever its result can be stored.
    assign advance  = r_in_valid && out_free;
    // The input register takes a new word when it is empty or being drained.
    assign in_take  = i_in_valid && (!r_in_valid || advance);

    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    i2c_rts_step u_step (
        .i_phase (r_phase),
        .i_ctx   (r_ctx),
        .i_word  (r_in_word),
        .o_phase (n_phase),
        .o_ctx   (n_ctx),
        .o_word  (n_out_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in_word;
        end
    end

    // State only moves when a step result is actually stored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ctx   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_ctx   <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

### hdl/i2c_rts_checker.sv
// Port-level checker of the I2C register transfer sequencer and its bind.
`include "i2c_register_transfer_sequencer_macros.svh"

module i2c_rts_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input i2c_rts_pkg::t_in_word  i_in_word,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input i2c_rts_pkg::t_out_word o_out_word
);
    import i2c_rts_pkg::*;

    // A taken start always launches a START with the transfer marked in progress.
    `I2C_RTS_ASSERT_NOW(a_start_launch, o_out_valid && o_out_word.accepted, o_out_word.bus_action == ACT_START && o_out_word.busy_res && o_out_word.op_result == RES_BUSY)

    // Once the sequencer is idle again, only a stop or nothing may be asked of the bus.
    `I2C_RTS_ASSERT_NOW(a_idle_action, o_out_valid && !o_out_word.busy_res, o_out_word.bus_action == ACT_NONE || o_out_word.bus_action == ACT_STOP)

    // A stored byte either continues the read or completes it successfully.
    `I2C_RTS_ASSERT_NOW(a_store_state, o_out_valid && o_out_word.store_valid, o_out_word.busy_res || (o_out_word.op_result == RES_OK && o_out_word.bus_action == ACT_STOP))

    // A stalled result word stays offered and unchanged.
    `I2C_RTS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

endmodule

bind i2c_register_transfer_sequencer i2c_rts_checker u_i2c_rts_checker (.*);

### tb/sv/tb_i2c_rts_scoreboard_pkg.sv
// Scoreboard class for the I2C register transfer sequencer: sequence predictor and result check.
package tb_i2c_rts_scoreboard_pkg;

    import i2c_rts_pkg::*;

    class i2c_rts_scoreboard;

        t_phase      seq_phase;
        t_ctx        seq_ctx;
        t_out_word   pending_results[$];
        int unsigned fail_count;

        function new();
            seq_phase  = PH_IDLE;
            seq_ctx    = '0;
            fail_count = 0;
        endfunction

        // An unexpected status ends the transfer and asks the host for a stop.
        function logic [2:0] abort_transfer(logic [2:0] code, logic [7:0] status);
            seq_ctx.result_code     = code;
            seq_ctx.last_error_code = status;
            seq_phase               = PH_IDLE;
            return ACT_STOP;
        endfunction

        // Advances the predicted sequencer by one accepted word and queues its result.
        function void note_input(t_in_word w);
            t_out_word  r;
            logic [7:0] next_done;
            logic       last_byte;
            r = '0;
            if (w.command == CMD_WRITE || w.command == CMD_READ) begin
                if (seq_phase == PH_IDLE) begin
                    r.accepted              = 1'b1;
                    seq_ctx.is_write        = (w.command == CMD_WRITE);
                    seq_ctx.target_address  = w.device_address;
                    seq_ctx.target_register = w.register_index;
                    seq_ctx.total_bytes     = w.byte_count;
                    seq_ctx.done_bytes      = 8'd0;
                    seq_ctx.result_code     = RES_BUSY;
                    seq_phase               = PH_START;
                    r.bus_action            = ACT_START;
                end
            end else if (w.command == CMD_EVENT) begin
                case (seq_phase)
                    PH_START: begin
                        if (w.bus_status == ST_START) begin
                            seq_phase    = PH_SLAW;
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = seq_ctx.target_address;
                        end else begin
                            // A failed start gives up without a stop.
                            seq_ctx.result_code     = RES_ESTART;
                            seq_ctx.last_error_code = w.bus_status;
                            seq_phase               = PH_IDLE;
                        end
                    end
                    PH_SLAW: begin
                        if (w.bus_status == ST_SLAW_ACK) begin
                            seq_phase    = PH_REG;
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = seq_ctx.target_register;
                        end else begin
                            r.bus_action = abort_transfer(RES_EADDR, w.bus_status);
                        end
                    end
                    PH_REG: begin
                        if (w.bus_status != ST_DATA_ACK) begin
                            r.bus_action = abort_transfer(RES_EWRITE, w.bus_status);
                        end else if (seq_ctx.is_write) begin
                            seq_phase          = PH_WDATA;
                            r.bus_action       = ACT_WRITE;
                            r.bus_byte         = w.write_byte;
                            r.byte_index       = seq_ctx.done_bytes;
                            seq_ctx.done_bytes = seq_ctx.done_bytes + 8'd1;
                        end else begin
                            seq_phase    = PH_RSTART;
                            r.bus_action = ACT_RSTART;
                        end
                    end
                    PH_WDATA: begin
                        if (w.bus_status != ST_DATA_ACK) begin
                            r.bus_action = abort_transfer(RES_EWRITE, w.bus_status);
                        end else if (seq_ctx.done_bytes == seq_ctx.total_bytes) begin
                            seq_ctx.result_code = RES_OK;
                            seq_phase           = PH_IDLE;
                            r.bus_action        = ACT_STOP;
                        end else begin
                            r.bus_action       = ACT_WRITE;
                            r.bus_byte         = w.write_byte;
                            r.byte_index       = seq_ctx.done_bytes;
                            seq_ctx.done_bytes = seq_ctx.done_bytes + 8'd1;
                        end
                    end
                    PH_RSTART: begin
                        if (w.bus_status == ST_REP_START) begin
                            seq_phase    = PH_SLAR;
                            r.bus_action = ACT_WRITE;
                            r.bus_byte   = seq_ctx.target_address | READ_BIT;
                        end else begin
                            r.bus_action = abort_transfer(RES_ERST, w.bus_status);
                        end
                    end
                    PH_SLAR: begin
                        if (w.bus_status == ST_SLAR_ACK) begin
                            seq_phase    = PH_RDATA;
                            r.bus_action = (seq_ctx.total_bytes == 8'd1) ? ACT_RNACK : ACT_RACK;
                        end else begin
                            r.bus_action = abort_transfer(RES_EREAD, w.bus_status);
                        end
                    end
                    PH_RDATA: begin
                        // The count wraps, so a count of zero runs for 256 bytes.
                        next_done = seq_ctx.done_bytes + 8'd1;
                        last_byte = (next_done == seq_ctx.total_bytes);
                        if (w.bus_status != (last_byte ? ST_RX_NACK : ST_RX_ACK)) begin
                            r.bus_action = abort_transfer(RES_EREAD, w.bus_status);
                        end else begin
                            r.store_valid      = 1'b1;
                            r.store_byte       = w.read_byte;
                            r.byte_index       = seq_ctx.done_bytes;
                            seq_ctx.done_bytes = next_done;
                            if (last_byte) begin
                                seq_ctx.result_code = RES_OK;
                                seq_phase           = PH_IDLE;
                                r.bus_action        = ACT_STOP;
                            end else begin
                                next_done    = seq_ctx.done_bytes + 8'd1;
                                r.bus_action = (next_done == seq_ctx.total_bytes) ?
                                               ACT_RNACK : ACT_RACK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.op_result    = seq_ctx.result_code;
            r.error_status = seq_ctx.last_error_code;
            r.busy_res     = (seq_phase != PH_IDLE);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                fail_count++;
            end
        endfunction

        // Checks one accepted result word against the oldest prediction.
        function void check_result(t_out_word got);
            t_out_word want;
            if (pending_results.size() == 0) begin
                $error("result word 0x%0h arrived with nothing predicted", got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
            compare_field("bus_action", 8'(want.bus_action), 8'(got.bus_action));
            compare_field("bus_byte", want.bus_byte, got.bus_byte);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("store_valid", 8'(want.store_valid), 8'(got.store_valid));
            compare_field("store_byte", want.store_byte, got.store_byte);
            compare_field("op_result", 8'(want.op_result), 8'(got.op_result));
            compare_field("error_status", want.error_status, got.error_status);
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

    endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench of the I2C register transfer sequencer: stimulus, handshakes and checking.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import i2c_rts_pkg::*;
    import tb_i2c_rts_scoreboard_pkg::*;

    // Command code that the block has to ignore.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Roughly how many meaningful words the random part sends.
    localparam int ITEM_TARGET = 1600;

    // Cycles without any accepted word on either channel before the run is given up.
    localparam int WATCHDOG_LIMIT = 1000;

    // Every status code the block knows; used to make near-miss errors.
    localparam logic [7:0] KNOWN_STATUS [7] = '{ST_START, ST_REP_START, ST_SLAW_ACK,
                                                ST_DATA_ACK, ST_SLAR_ACK, ST_RX_ACK,
                                                ST_RX_NACK};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    i2c_rts_scoreboard sb = new();

    // While set, neither side leaves gaps, so words run back to back.
    bit quiet = 1'b0;
    int items_sent = 0;
    int idle_cycles = 0;

    i2c_register_transfer_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #6 i_clk = ~i_clk;

    // Each side draws how long it holds off before its next word.
    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // A random byte.
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_word make_word(logic [1:0] cmd, logic [7:0] addr,
                                           logic [7:0] reg_idx, logic [7:0] cnt,
                                           logic [7:0] status, logic [7:0] wr_byte,
                                           logic [7:0] rd_byte);
        t_in_word w;
        w.command        = cmd;
        w.device_address = addr;
        w.register_index = reg_idx;
        w.byte_count     = cnt;
        w.bus_status     = status;
        w.write_byte     = wr_byte;
        w.read_byte      = rd_byte;
        return w;
    endfunction

    // Offers one word after a random gap and holds it until the block takes it.
    // When the gap is zero the valid stays high from the previous word, so the
    // valid only ever gets one assignment per clock edge.
    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(w);
    endtask

    // A start command; the status and data fields carry noise the block must ignore.
    task automatic start_xfer(input logic [1:0] cmd, input logic [7:0] addr,
                              input logic [7:0] reg_idx, input logic [7:0] cnt);
        send_word(make_word(cmd, addr, reg_idx, cnt, rand_byte(), rand_byte(),
                            rand_byte()));
    endtask

    // A bus status event; the start fields carry noise the block must ignore.
    task automatic bus_event(input logic [7:0] status, input logic [7:0] wr_byte,
                             input logic [7:0] rd_byte);
        send_word(make_word(CMD_EVENT, rand_byte(), rand_byte(), rand_byte(), status,
                            wr_byte, rd_byte));
    endtask

    // One well-formed register transfer with random content. Up to a quarter of them
    // break off with a wrong status, often early so that every phase sees errors,
    // and now and then a start command is thrown in while the block is busy.
    task automatic random_transfer();
        logic [1:0] cmd;
        logic [7:0] cnt;
        logic [7:0] good_status;
        logic [7:0] sent_status;
        int         n_data;
        int         n_events;
        int         err_at;
        int         ev_idx;
        int         pick;
        cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        pick = int'($urandom_range(0, 99));
        if (pick < 85) begin
            cnt = 8'($urandom_range(1, 8));
        end else if (pick < 95) begin
            cnt = 8'($urandom_range(9, 40));
        end else begin
            // Full range, including zero for a 256-byte transfer.
            cnt = rand_byte();
        end
        n_data   = (cnt == 8'd0) ? 256 : int'(cnt);
        n_events = (cmd == CMD_WRITE) ? 3 + n_data : 5 + n_data;
        err_at   = -1;
        if ($urandom_range(0, 3) == 0) begin
            err_at = $urandom_range(0, 1) ? int'($urandom_range(0, 5)) :
                                            int'($urandom_range(0, n_events - 1));
        end
        quiet = ($urandom_range(0, 4) == 0);

        start_xfer(cmd, rand_byte(), rand_byte(), cnt);
        items_sent++;
        for (ev_idx = 0; ev_idx < n_events; ev_idx++) begin
            if ($urandom_range(0, 24) == 0) begin
                start_xfer(2'($urandom_range(1, 3)), rand_byte(), rand_byte(), rand_byte());
            end
            // The status the sequence expects at this point.
            case (ev_idx)
                0:       good_status = ST_START;
                1:       good_status = ST_SLAW_ACK;
                2:       good_status = ST_DATA_ACK;
                3:       good_status = (cmd == CMD_WRITE) ? ST_DATA_ACK : ST_REP_START;
                4:       good_status = (cmd == CMD_WRITE) ? ST_DATA_ACK : ST_SLAR_ACK;
                default: begin
                    if (cmd == CMD_WRITE) begin
                        good_status = ST_DATA_ACK;
                    end else begin
                        good_status = (ev_idx == n_events - 1) ? ST_RX_NACK : ST_RX_ACK;
                    end
                end
            endcase
            sent_status = good_status;
            if (ev_idx == err_at) begin
                sent_status = $urandom_range(0, 1) ? KNOWN_STATUS[3'($urandom_range(0, 6))] :
                                                     rand_byte();
            end
            bus_event(sent_status, rand_byte(), rand_byte());
            items_sent++;
            if (sent_status != good_status) begin
                break;
            end
        end
    endtask

    // Output side: stall for a random number of cycles, then take one word.
    initial begin
        int unsigned hold;
        forever begin
            hold = draw_wait();
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Every result taken by the output side is checked against the prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_word);
        end
    end

    // The watchdog restarts whenever either channel moves a word.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("i2c_register_transfer_sequencer verification failed");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. First, words that an idle block must ignore: an event
        // and the unused command with every field bit set.
        bus_event(ST_START, 8'h00, 8'h00);
        send_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

        // A two-byte write to address zero, with a refused start while it is busy.
        start_xfer(CMD_WRITE, 8'h00, 8'hFF, 8'd2);
        start_xfer(CMD_READ, 8'hFF, 8'h00, 8'd1);
        bus_event(ST_START, 8'h00, 8'h00);
        bus_event(ST_SLAW_ACK, 8'h00, 8'h00);
        bus_event(ST_DATA_ACK, 8'hFF, 8'h00);
        bus_event(ST_DATA_ACK, 8'h00, 8'hFF);
        bus_event(ST_DATA_ACK, 8'h5A, 8'h00);

        // A one-byte read: the first data byte is already the last one, so it
        // is read with a nack and completes the transfer when it arrives.
        start_xfer(CMD_READ, 8'hFE, 8'h00, 8'd1);
        bus_event(ST_START, 8'h00, 8'h00);
        bus_event(ST_SLAW_ACK, 8'h00, 8'h00);
        bus_event(ST_DATA_ACK, 8'h00, 8'h00);
        bus_event(ST_REP_START, 8'h00, 8'h00);
        bus_event(ST_SLAR_ACK, 8'h00, 8'hFF);
        bus_event(ST_RX_NACK, 8'h00, 8'hFF);

        // A failed start leaves without a stop.
        start_xfer(CMD_WRITE, 8'hFF, 8'h80, 8'd255);
        bus_event(8'hFF, 8'h00, 8'h00);

        // A 256-byte read refused at the register byte.
        start_xfer(CMD_READ, 8'h5A, 8'h01, 8'd0);
        bus_event(ST_START, 8'h00, 8'h00);
        bus_event(ST_SLAW_ACK, 8'h00, 8'h00);
        bus_event(8'h00, 8'h00, 8'h00);

        // Random part: mostly whole transfers, with idle noise in between.
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) begin
                if ($urandom_range(0, 1)) begin
                    bus_event(rand_byte(), rand_byte(), rand_byte());
                end else begin
                    start_xfer(CMD_UNUSED, rand_byte(), rand_byte(), rand_byte());
                end
            end
            random_transfer();
        end

        // Drain: wait for every predicted result, then a few more cycles in case
        // the block produces something it should not.
        i_in_valid <= 1'b0;
        quiet = 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.outstanding() == 0) begin
            $display("i2c_register_transfer_sequencer verification clean");
        end else begin
            $display("i2c_register_transfer_sequencer verification failed");
        end
        $finish;
    end

endmodule
